[rtl/nsd_pkg.sv]
// Package for the netstring stream deframer: parse phases, result kinds,
// error codes, character codes and default sizes. No dependencies.
package nsd_pkg;

  localparam int unsigned LEN_WIDTH_DEFAULT = 16;
  localparam int unsigned CFG_WIDTH         = 16;
  localparam logic [CFG_WIDTH-1:0] MAX_LEN_RESET = 16'hFFFF;

  typedef enum logic [1:0] {
    PH_DIGITS  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_COMMA   = 2'd2,
    PH_DISCARD = 2'd3
  } phase_e;

  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_END   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [2:0] ERR_NONE   = 3'd0;
  localparam logic [2:0] ERR_DIGITS = 3'd1;
  localparam logic [2:0] ERR_LONG   = 3'd2;
  localparam logic [2:0] ERR_COMMA  = 3'd3;
  localparam logic [2:0] ERR_TRUNC  = 3'd4;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;

  // Parser flags that travel between the state registers and the parser.
  typedef struct packed {
    phase_e phase;
    logic   saw_digit;
    logic   leading_zero;
  } nsd_flags_t;

  // One result of a parse step.
  typedef struct packed {
    logic       valid;
    logic [1:0] kind;
    logic [7:0] pbyte;
    logic [2:0] code;
  } nsd_result_t;

endpackage

[rtl/nsd_stream_if.sv]
// Stream interfaces for the netstring deframer: byte input and result output.
// Valid/ready handshake; no dependencies.
interface nsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_buffer;

  modport source (output valid, in_byte, end_of_buffer, input ready);
  modport sink   (input valid, in_byte, end_of_buffer, output ready);
endinterface

interface nsd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] payload_byte;
  logic [2:0] error_code;

  modport source (output valid, result_kind, payload_byte, error_code, input ready);
  modport sink   (input valid, result_kind, payload_byte, error_code, output ready);
endinterface

[rtl/nsd_parser.sv]
// Combinational parse step of the netstring deframer: next state and result
// for one byte. Depends on nsd_pkg.
module nsd_parser import nsd_pkg::*; #(
  parameter int unsigned LEN_WIDTH = LEN_WIDTH_DEFAULT
) (
  input  logic [7:0]           byte_i,
  input  logic                 last_i,
  input  logic [LEN_WIDTH-1:0] limit_i,
  input  nsd_flags_t           flags_i,
  input  logic [LEN_WIDTH-1:0] len_i,
  output nsd_flags_t           flags_o,
  output logic [LEN_WIDTH-1:0] len_o,
  output nsd_result_t          result_o
);

  localparam int unsigned VW = LEN_WIDTH + 4;

  logic          is_digit;
  logic [3:0]    digit;
  logic [VW-1:0] len_ext;
  logic [VW-1:0] limit_ext;
  logic [VW-1:0] digit_ext;
  logic [VW-1:0] acc;

  assign is_digit  = (byte_i >= CHAR_ZERO) && (byte_i <= CHAR_NINE);
  assign digit     = byte_i[3:0];
  assign len_ext   = VW'(len_i);
  assign limit_ext = VW'(limit_i);
  assign digit_ext = VW'(digit);
  // len * 10 + digit as two shifts and adds
  assign acc       = (len_ext << 3) + (len_ext << 1) + digit_ext;

  always_comb begin
    logic [2:0] err;
    logic       emit;
    logic       complete;
    logic [1:0] kind;
    err      = ERR_NONE;
    emit     = 1'b0;
    complete = 1'b0;
    kind     = KIND_BYTE;
    flags_o  = flags_i;
    len_o    = len_i;
    result_o = '0;

    unique case (flags_i.phase)
      PH_DIGITS: begin
        if (is_digit) begin
          if (!flags_i.saw_digit) begin
            flags_o.saw_digit    = 1'b1;
            flags_o.leading_zero = (digit == 4'd0);
            if (digit_ext > limit_ext) err = ERR_LONG;
            else len_o = LEN_WIDTH'(digit);
          end else if (flags_i.leading_zero) begin
            err = ERR_DIGITS;
          end else if (acc > limit_ext) begin
            err = ERR_LONG;
          end else begin
            len_o = acc[LEN_WIDTH-1:0];
          end
        end else if ((byte_i == CHAR_COLON) && flags_i.saw_digit) begin
          flags_o.saw_digit    = 1'b0;
          flags_o.leading_zero = 1'b0;
          flags_o.phase        = (len_i == '0) ? PH_COMMA : PH_PAYLOAD;
        end else begin
          err = ERR_DIGITS;
        end
      end
      PH_PAYLOAD: begin
        emit  = 1'b1;
        kind  = KIND_BYTE;
        len_o = len_i - LEN_WIDTH'(1);
        if (len_o == '0) flags_o.phase = PH_COMMA;
      end
      PH_COMMA: begin
        if (byte_i == CHAR_COMMA) begin
          emit     = 1'b1;
          kind     = KIND_END;
          complete = 1'b1;
        end else begin
          err = ERR_COMMA;
        end
      end
      PH_DISCARD: begin
      end
    endcase

    // a closing comma or the end of the buffer starts a fresh element
    if (complete || last_i) begin
      flags_o = '{phase: PH_DIGITS, saw_digit: 1'b0, leading_zero: 1'b0};
      len_o   = '0;
    end

    if (flags_i.phase == PH_DISCARD) begin
      result_o.valid = 1'b0;
    end else if (err != ERR_NONE) begin
      if (!last_i) flags_o.phase = PH_DISCARD;
      result_o = '{valid: 1'b1, kind: KIND_ERROR, pbyte: 8'h00, code: err};
    end else if (last_i && !complete) begin
      result_o = '{valid: 1'b1, kind: KIND_ERROR, pbyte: 8'h00, code: ERR_TRUNC};
    end else if (emit) begin
      result_o = '{valid: 1'b1, kind: kind,
                   pbyte: (kind == KIND_BYTE) ? byte_i : 8'h00, code: ERR_NONE};
    end
  end

endmodule

[rtl/netstring_stream_deframer.sv]
// Netstring stream deframer top level: state and result registers around the
// parse step. Depends on nsd_pkg, nsd_stream_if and nsd_parser.
//
//  channel   dir   handshake        payload
//  in_i      in    valid / ready    in_byte[7:0], end_of_buffer
//  out_o     out   valid / ready    result_kind[1:0], payload_byte[7:0], error_code[2:0]
//  cfg       in    cfg_we_i         cfg_wdata_i[15:0] = max_payload_length
//
// One byte per cycle: the parse step for a byte takes the cycle of its transfer,
// and its result (if any) shows on out_o in the next cycle from the result register.
// The input stalls only while a held result is not taken in the same cycle.
// Reset clears the parse state, empties the result register and sets the length limit to its
// maximum. The user must write configuration only while the stream is idle; it is not enforced.
module netstring_stream_deframer import nsd_pkg::*; #(
  parameter int unsigned LEN_WIDTH = LEN_WIDTH_DEFAULT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  nsd_in_if.sink               in_i,
  nsd_out_if.source            out_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_WIDTH-1:0] cfg_wdata_i
);

  // Hold the limit already clipped to what the length counter can hold.
  localparam int unsigned CW = (LEN_WIDTH > CFG_WIDTH) ? LEN_WIDTH : CFG_WIDTH;
  localparam logic [CW-1:0] LEN_MASK = CW'((64'd1 << LEN_WIDTH) - 64'd1);
  localparam logic [CW-1:0] MAX_EXT  = CW'(MAX_LEN_RESET);
  localparam logic [LEN_WIDTH-1:0] LIMIT_RESET =
      LEN_WIDTH'((MAX_EXT < LEN_MASK) ? MAX_EXT : LEN_MASK);

  logic [LEN_WIDTH-1:0] limit_q;
  logic [CW-1:0]        wdata_ext;

  nsd_flags_t           flags_q, flags_d;
  logic [LEN_WIDTH-1:0] len_q, len_d;
  nsd_result_t          step_res;

  logic       out_valid_q;
  logic [1:0] kind_q;
  logic [7:0] pbyte_q;
  logic [2:0] code_q;

  logic in_xfer;

  assign wdata_ext = CW'(cfg_wdata_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= LEN_WIDTH'((wdata_ext < LEN_MASK) ? wdata_ext : LEN_MASK);
    end
  end

  nsd_parser #(.LEN_WIDTH(LEN_WIDTH)) u_parser (
    .byte_i   (in_i.in_byte),
    .last_i   (in_i.end_of_buffer),
    .limit_i  (limit_q),
    .flags_i  (flags_q),
    .len_i    (len_q),
    .flags_o  (flags_d),
    .len_o    (len_d),
    .result_o (step_res)
  );

  // Accept a byte whenever the result register is empty or drains this cycle.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign in_xfer    = in_i.valid && in_i.ready;

  // Advance the parse state on each input transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '{phase: PH_DIGITS, saw_digit: 1'b0, leading_zero: 1'b0};
      len_q   <= '0;
    end else if (in_xfer) begin
      flags_q <= flags_d;
      len_q   <= len_d;
    end
  end

  // Result register: load on a transfer that yields a result, drop when taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= step_res.valid;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && step_res.valid) begin
      kind_q  <= step_res.kind;
      pbyte_q <= step_res.pbyte;
      code_q  <= step_res.code;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result_kind  = kind_q;
  assign out_o.payload_byte = pbyte_q;
  assign out_o.error_code   = code_q;

  // An error result always carries a code, and other results never do.
  a_code_matches_kind : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ((out_o.result_kind == KIND_ERROR) == (out_o.error_code != ERR_NONE)))
    else $error("error code does not match result kind");

  // In the payload phase at least one byte is still owed.
  a_payload_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (flags_q.phase == PH_PAYLOAD) |-> (len_q != '0))
    else $error("payload phase with zero bytes left");

  // The flagged last byte returns the parser to the start of an element.
  a_eob_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_i.end_of_buffer) |=>
      (flags_q.phase == PH_DIGITS && len_q == '0 && !flags_q.saw_digit))
    else $error("parser not restarted after end of buffer");

endmodule
